@@ rtl/pst_pkg.sv @@
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants of the priority task scheduler
// Holds the transfer payload structs, the internal command format that passes
// from the front end to the execution unit, and the scheduler constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

	// Number of task slots and the width of a slot index.
	localparam int TASK_SLOTS = 8;
	localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	// A priority at or above this value is never a candidate in the selection scan.
	localparam logic [7:0] PRIO_LIMIT = 8'd100;

	// Command queue between the front end and the execution unit.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Encoding of the kind field of a request.
	localparam logic [2:0] KIND_CREATE    = 3'd0;
	localparam logic [2:0] KIND_START     = 3'd1;
	localparam logic [2:0] KIND_DELAY     = 3'd2;
	localparam logic [2:0] KIND_TICK      = 3'd3;
	localparam logic [2:0] KIND_IRQ_ENTER = 3'd4;
	localparam logic [2:0] KIND_IRQ_EXIT  = 3'd5;

	typedef enum logic [2:0] {
		OP_CREATE,
		OP_START,
		OP_DELAY,
		OP_TICK,
		OP_IRQ_ENTER,
		OP_IRQ_EXIT,
		OP_NOP
	} op_e;

	typedef enum logic [1:0] {
		DISP_NONE   = 2'd0,
		DISP_FIRST  = 2'd1,
		DISP_SWITCH = 2'd2
	} disp_e;

	typedef enum logic {
		EX_IDLE,
		EX_SCAN
	} ex_state_e;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  priority_req;
		logic [15:0] delay_ticks;
	} req_t;

	typedef struct packed {
		logic [2:0]  chosen_task;
		logic [1:0]  dispatch;
		logic        table_full;
		logic [31:0] switch_count;
		logic [31:0] tick_count;
	} rsp_t;

	typedef struct packed {
		op_e         op;
		logic [7:0]  prio;
		logic [15:0] delay;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/priority_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// priority_task_scheduler: fixed-priority preemptive task selector
// Each request is one kernel event; each produces exactly one response with
// the running slot, the dispatch code, the table-full flag and the counters.
//
// Channels: the request channel (req_valid, req_stall, req) and the response
// channel (rsp_valid, rsp_stall, rsp). A transfer happens on a rising edge
// where valid is high and stall is low. Responses come out in request order.
//
// Flow: a transfer is registered by the front end, queued, and taken by
// the execution unit, which registers the response. Events that need no
// selection (tick, interrupt enter, a start, delay, create or exit that
// does not reschedule, ignored codes) pass the front register, the queue
// and the output register, and can follow one another every cycle while
// the response side does not stall. Events that run the selector (start
// of the kernel, and while it runs a delay, a create into a free slot or
// an interrupt exit to depth zero) spend one slot per cycle in the
// selection scan; the execution unit takes no new command until it is done.
//
// Reset: arst_n clears the task table, the kernel flags and both counters;
// the block takes requests as soon as reset is released.
// A stalled response holds in the output register; up to three further
// requests are absorbed by the front register and queue before req_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_scheduler import pst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// Front end to queue.
	logic push;
	cmd_t push_cmd;
	logic q_full;

	// Queue to execution unit.
	logic pop;
	cmd_t pop_cmd;
	logic q_empty;

	pst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.cmd       (push_cmd),
		.q_full    (q_full)
	);

	pst_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_cmd),
		.full    (q_full),
		.pop     (pop),
		.rd_data (pop_cmd),
		.empty   (q_empty)
	);

	// The execution unit owns the task table and the response register.
	pst_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pop_cmd),
		.empty     (q_empty),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

@@ rtl/pst_front.sv @@
// ----------------------------------------------------------------------------
// pst_front: request intake and decode
// Registers each accepted request, decodes its kind into an internal command
// and pushes it into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_front import pst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic push,
	output cmd_t cmd,
	input  logic q_full
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;

	always_comb begin
		cmd_d.prio  = req.priority_req;
		cmd_d.delay = req.delay_ticks;
		case (req.kind)
			KIND_CREATE:    cmd_d.op = OP_CREATE;
			KIND_START:     cmd_d.op = OP_START;
			KIND_DELAY:     cmd_d.op = OP_DELAY;
			KIND_TICK:      cmd_d.op = OP_TICK;
			KIND_IRQ_ENTER: cmd_d.op = OP_IRQ_ENTER;
			KIND_IRQ_EXIT:  cmd_d.op = OP_IRQ_EXIT;
			default:        cmd_d.op = OP_NOP;
		endcase
	end

	assign req_stall = valid_s1 && q_full;
	assign push      = valid_s1 && !q_full;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pst_queue.sv @@
// ----------------------------------------------------------------------------
// pst_queue: command queue
// Short first-in first-out buffer that decouples the front end from the
// execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_queue import pst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_data,
	output logic full,
	input  logic pop,
	output cmd_t rd_data,
	output logic empty
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pst_exec.sv @@
// ----------------------------------------------------------------------------
// pst_exec: scheduler execution unit
// Holds the task table and kernel state, applies each command, scans the
// slots one per cycle when a selection is due, and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_exec import pst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic empty,
	output logic pop,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ex_state_e         state_q;
	ex_state_e         state_d;

	logic [TASK_SLOTS-1:0] used_q;
	logic [TASK_SLOTS-1:0] delayed_q;
	logic [7:0]            prio_q  [TASK_SLOTS];
	logic [15:0]           count_q [TASK_SLOTS];

	logic [SLOT_W-1:0] running_q;
	logic              kr_q;
	logic              have_q;
	logic              first_q;
	logic [7:0]        depth_q;
	logic [31:0]       switches_q;
	logic [31:0]       ticks_q;

	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] pick_q;
	logic [7:0]        best_q;

	logic              out_valid_q;
	rsp_t              out_q;

	logic              out_free;
	logic              need_scan;
	logic              tbl_full;
	logic [SLOT_W-1:0] free_idx;
	logic              cand;
	logic              last;
	logic              finish;
	logic [SLOT_W-1:0] pick_d;
	logic [7:0]        best_d;
	disp_e             sel_disp;
	logic [SLOT_W-1:0] sel_running;
	logic [31:0]       sel_switches;
	logic [31:0]       ticks_d;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Lowest free slot.
	always_comb begin
		tbl_full = 1'b1;
		free_idx = '0;
		for (int s = TASK_SLOTS - 1; s >= 0; s--) begin
			if (!used_q[s]) begin
				tbl_full = 1'b0;
				free_idx = SLOT_W'(s);
			end
		end
	end

	// Commands that end in a selection pass.
	always_comb begin
		case (cmd.op)
			OP_CREATE:   need_scan = !tbl_full && kr_q;
			OP_START:    need_scan = !kr_q && have_q;
			OP_DELAY:    need_scan = kr_q;
			OP_IRQ_EXIT: need_scan = (depth_q == 8'd1) && kr_q && have_q;
			default:     need_scan = 1'b0;
		endcase
	end

	assign ticks_d = (cmd.op == OP_TICK) ? ticks_q + 32'd1 : ticks_q;

	// One slot of the selection scan; strict compare keeps the lowest index on ties.
	assign cand   = used_q[idx_q] && !delayed_q[idx_q] && (prio_q[idx_q] < best_q);
	assign best_d = cand ? prio_q[idx_q] : best_q;
	assign pick_d = cand ? idx_q : pick_q;
	assign last   = (idx_q == SLOT_W'(TASK_SLOTS - 1));

	always_comb begin
		sel_running  = pick_d;
		sel_switches = switches_q;
		if (first_q) begin
			sel_disp = DISP_FIRST;
		end else if (running_q == pick_d) begin
			sel_disp = DISP_NONE;
		end else begin
			sel_disp     = DISP_SWITCH;
			sel_switches = switches_q + 32'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		finish  = 1'b0;
		case (state_q)
			EX_IDLE: begin
				if (!empty && out_free) begin
					pop = 1'b1;
					if (need_scan) begin
						state_d = EX_SCAN;
					end
				end
			end
			EX_SCAN: begin
				if (last) begin
					finish  = 1'b1;
					state_d = EX_IDLE;
				end
			end
			default: state_d = EX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scheduler state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			delayed_q  <= '0;
			for (int s = 0; s < TASK_SLOTS; s++) begin
				prio_q[s]  <= PRIO_LIMIT;
				count_q[s] <= '0;
			end
			running_q  <= '0;
			kr_q       <= 1'b0;
			have_q     <= 1'b0;
			first_q    <= 1'b1;
			depth_q    <= '0;
			switches_q <= '0;
			ticks_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((pop && !need_scan) || finish) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end

			if (pop) begin
				case (cmd.op)
					OP_CREATE: begin
						if (!tbl_full) begin
							used_q[free_idx]    <= 1'b1;
							prio_q[free_idx]    <= cmd.prio;
							delayed_q[free_idx] <= 1'b0;
							count_q[free_idx]   <= '0;
							have_q              <= 1'b1;
						end
					end
					OP_START: begin
						if (!kr_q && have_q) begin
							kr_q <= 1'b1;
						end
					end
					OP_DELAY: begin
						if (cmd.delay != '0) begin
							delayed_q[running_q] <= 1'b1;
							count_q[running_q]   <= cmd.delay;
						end
					end
					OP_TICK: begin
						ticks_q <= ticks_d;
						for (int s = 0; s < TASK_SLOTS; s++) begin
							if (delayed_q[s]) begin
								if (count_q[s] <= 16'd1) begin
									delayed_q[s] <= 1'b0;
									count_q[s]   <= '0;
								end else begin
									count_q[s] <= count_q[s] - 16'd1;
								end
							end
						end
					end
					OP_IRQ_ENTER: begin
						if (depth_q != 8'hFF) begin
							depth_q <= depth_q + 8'd1;
						end
					end
					OP_IRQ_EXIT: begin
						if (depth_q != '0) begin
							depth_q <= depth_q - 8'd1;
						end
					end
					default: begin
					end
				endcase
			end

			if (finish) begin
				running_q  <= sel_running;
				first_q    <= 1'b0;
				switches_q <= sel_switches;
			end
		end
	end

	// Scan registers and response payload.
	always_ff @(posedge clk) begin
		if (pop && need_scan) begin
			idx_q  <= '0;
			best_q <= PRIO_LIMIT;
			pick_q <= '0;
		end else if (state_q == EX_SCAN) begin
			idx_q  <= idx_q + 1'b1;
			best_q <= best_d;
			pick_q <= pick_d;
		end

		if (pop && !need_scan) begin
			out_q.chosen_task  <= 3'(running_q);
			out_q.dispatch     <= DISP_NONE;
			out_q.table_full   <= (cmd.op == OP_CREATE) && tbl_full;
			out_q.switch_count <= switches_q;
			out_q.tick_count   <= ticks_d;
		end else if (finish) begin
			out_q.chosen_task  <= 3'(sel_running);
			out_q.dispatch     <= sel_disp;
			out_q.table_full   <= 1'b0;
			out_q.switch_count <= sel_switches;
			out_q.tick_count   <= ticks_q;
		end
	end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the priority task scheduler
// Drives kernel events through the request channel with bursty timing, keeps
// its own model of the task table and the kernel flags, and compares every
// response field by field against the model while the response side stalls
// on a pattern of its own.
// ----------------------------------------------------------------------------

module tb_top;
	import pst_pkg::*;

	// Kind codes that the block decodes as no operation.
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	// Number of random events after the directed part.
	localparam int RANDOM_EVENTS = 40;

	// Mismatches past this count are only counted, not printed.
	localparam int REPORT_LIMIT = 10;

	typedef enum {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_LONG
	} stall_mode_e;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	req_t req       = '0;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;

	priority_task_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Scheduler model. This is the bench's own copy of the task table and
	// kernel flags; it advances by one event per accepted request transfer.
	// ------------------------------------------------------------------
	logic              slot_busy   [TASK_SLOTS];
	logic [7:0]        slot_prio   [TASK_SLOTS];
	logic              slot_asleep [TASK_SLOTS];
	logic [15:0]       slot_wait   [TASK_SLOTS];
	logic [SLOT_W-1:0] cur_slot;
	logic              kernel_on;
	logic              any_task;
	logic              first_dispatch_due;
	logic [7:0]        irq_depth;
	logic [31:0]       switch_total;
	logic [31:0]       tick_total;
	logic [7:0]        peak_depth;

	// Expected responses, oldest first.
	rsp_t pending_sched_rsp [$];

	int events_sent;
	int mismatches;
	int seen_first;
	int seen_switch;
	int seen_full;
	int burst_left;

	function automatic void clear_sched_model();
		for (int s = 0; s < TASK_SLOTS; s++) begin
			slot_busy[s]   = 1'b0;
			slot_prio[s]   = PRIO_LIMIT;
			slot_asleep[s] = 1'b0;
			slot_wait[s]   = '0;
		end
		cur_slot           = '0;
		kernel_on          = 1'b0;
		any_task           = 1'b0;
		first_dispatch_due = 1'b1;
		irq_depth          = '0;
		switch_total       = '0;
		tick_total         = '0;
		peak_depth         = '0;
	endfunction

	// Picks the ready slot with the lowest priority number below the limit.
	// Ties go to the lowest index, and with nothing eligible slot 0 is the
	// pick. Outside a running kernel the scan has no effect at all.
	function automatic disp_e select_task();
		logic [7:0]        best;
		logic [SLOT_W-1:0] pick;
		best = PRIO_LIMIT;
		pick = '0;
		for (int s = 0; s < TASK_SLOTS; s++) begin
			if (slot_busy[s] && !slot_asleep[s] && slot_prio[s] < best) begin
				best = slot_prio[s];
				pick = s[SLOT_W-1:0];
			end
		end
		if (!kernel_on)
			return DISP_NONE;
		if (first_dispatch_due) begin
			first_dispatch_due = 1'b0;
			cur_slot = pick;
			return DISP_FIRST;
		end
		if (cur_slot == pick)
			return DISP_NONE;
		switch_total = switch_total + 32'd1;
		cur_slot = pick;
		return DISP_SWITCH;
	endfunction

	// Applies one kernel event to the model and returns the response it
	// should produce.
	function automatic rsp_t schedule_event(input req_t r);
		rsp_t  out;
		disp_e disp;
		logic  full;
		int    free_slot;
		disp      = DISP_NONE;
		full      = 1'b0;
		free_slot = -1;
		case (r.kind)
			KIND_CREATE: begin
				for (int s = TASK_SLOTS - 1; s >= 0; s--)
					if (!slot_busy[s])
						free_slot = s;
				if (free_slot < 0) begin
					full = 1'b1;
				end else begin
					slot_busy[free_slot]   = 1'b1;
					slot_prio[free_slot]   = r.priority_req;
					slot_asleep[free_slot] = 1'b0;
					slot_wait[free_slot]   = '0;
					any_task = 1'b1;
					if (kernel_on)
						disp = select_task();
				end
			end
			KIND_START: begin
				if (!kernel_on && any_task) begin
					kernel_on = 1'b1;
					disp = select_task();
				end
			end
			KIND_DELAY: begin
				// The delay hits whatever the running slot holds, used or not.
				if (r.delay_ticks != '0) begin
					slot_asleep[cur_slot] = 1'b1;
					slot_wait[cur_slot]   = r.delay_ticks;
				end
				disp = select_task();
			end
			KIND_TICK: begin
				tick_total = tick_total + 32'd1;
				for (int s = 0; s < TASK_SLOTS; s++) begin
					if (slot_asleep[s]) begin
						if (slot_wait[s] <= 16'd1) begin
							slot_asleep[s] = 1'b0;
							slot_wait[s]   = '0;
						end else begin
							slot_wait[s] = slot_wait[s] - 16'd1;
						end
					end
				end
			end
			KIND_IRQ_ENTER: begin
				if (irq_depth != 8'hFF)
					irq_depth = irq_depth + 8'd1;
				if (irq_depth > peak_depth)
					peak_depth = irq_depth;
			end
			KIND_IRQ_EXIT: begin
				if (irq_depth != '0) begin
					irq_depth = irq_depth - 8'd1;
					if (irq_depth == '0 && kernel_on && any_task)
						disp = select_task();
				end
			end
			default: begin
			end
		endcase
		out.chosen_task  = cur_slot;
		out.dispatch     = disp;
		out.table_full   = full;
		out.switch_count = switch_total;
		out.tick_count   = tick_total;
		return out;
	endfunction

	// ------------------------------------------------------------------
	// Request side. The sender works in bursts; between bursts it drops
	// valid for a random gap. Valid is only lowered at the start of a gap,
	// never in the step where the next transfer is offered, so it stays
	// high across back-to-back transfers. The model is advanced at the
	// edge where the transfer happens.
	// ------------------------------------------------------------------
	task automatic send_event(input logic [2:0] kind, input logic [7:0] prio,
			input logic [15:0] dly);
		req_t item;
		int   gap;
		item.kind         = kind;
		item.priority_req = prio;
		item.delay_ticks  = dly;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 9);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req       <= item;
		req_valid <= 1'b1;
		// Stall is settled by the falling edge and holds until the next
		// rising edge, so sampling it there decides the transfer cleanly.
		do @(negedge clk); while (req_stall);
		@(posedge clk);
		pending_sched_rsp.push_back(schedule_event(item));
		events_sent++;
	endtask

	// Holds the request side idle until every expected response is back.
	task automatic wait_for_responses();
		req_valid <= 1'b0;
		while (pending_sched_rsp.size() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	// ------------------------------------------------------------------
	// Response side. The stall pattern changes character after a random
	// run of cycles: no stall at all, light random stall, heavy random stall, or
	// long regular holds that back the block up into its request queue.
	// ------------------------------------------------------------------
	stall_mode_e stall_mode = STALL_NONE;
	int          stall_left = 0;
	int          stall_cyc  = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		stall_cyc++;
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 1);
			default:     rsp_stall <= ((stall_cyc % 24) < 14);
		endcase
	end

	// A response whose valid is high and stall low at the falling edge is
	// transferred at the next rising edge; it is checked here.
	task automatic check_response(input rsp_t got);
		rsp_t want;
		if (pending_sched_rsp.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%t: response with nothing expected: task %0d disp %0d full %0d",
					$realtime, got.chosen_task, got.dispatch, got.table_full);
			return;
		end
		want = pending_sched_rsp.pop_front();
		if (got.dispatch == DISP_FIRST)
			seen_first++;
		if (got.dispatch == DISP_SWITCH)
			seen_switch++;
		if (got.table_full)
			seen_full++;
		if (got.chosen_task !== want.chosen_task || got.dispatch !== want.dispatch
				|| got.table_full !== want.table_full
				|| got.switch_count !== want.switch_count
				|| got.tick_count !== want.tick_count) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("%t: response mismatch", $realtime);
				$display("  expected: task %0d disp %0d full %0d switches %0d ticks %0d",
					want.chosen_task, want.dispatch, want.table_full,
					want.switch_count, want.tick_count);
				$display("  actual:   task %0d disp %0d full %0d switches %0d ticks %0d",
					got.chosen_task, got.dispatch, got.table_full,
					got.switch_count, got.tick_count);
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_response(rsp);
	end

	// ------------------------------------------------------------------
	// Directed tests. They run in order and each relies on the table state
	// that the previous one left behind.
	// ------------------------------------------------------------------

	// Events before any task exists: an exit at depth zero and a start with
	// an empty table are both ignored, and the delay lands on the idle slot 0.
	task automatic test_before_start();
		send_event(KIND_IRQ_EXIT, 8'hFF, 16'hFFFF);
		send_event(KIND_START, 8'h00, 16'h0000);
		send_event(KIND_TICK, 8'hA5, 16'h5A5A);
		send_event(KIND_DELAY, 8'h5A, 16'd5);
		send_event(KIND_SPARE_LO, 8'h3C, 16'hC3C3);
		send_event(KIND_SPARE_HI, 8'hC3, 16'h3C3C);
	endtask

	// Slot 0 gets a priority that can never win; slots 1 and 2 tie, so the
	// lower index takes the first dispatch. A second start is ignored.
	task automatic test_create_and_start();
		send_event(KIND_CREATE, 8'd255, 16'h0000);
		send_event(KIND_CREATE, 8'd40, 16'hFFFF);
		send_event(KIND_CREATE, 8'd40, 16'h0000);
		send_event(KIND_START, 8'd0, 16'h0000);
		send_event(KIND_START, 8'd0, 16'h0000);
	endtask

	// Delay paths: a zero delay keeps the task ready, a short delay hands the
	// processor to the tied slot and ticks wake it again, and once nothing is
	// eligible the pick falls back to slot 0, even when slot 0 is already
	// the running one.
	task automatic test_delay_paths();
		send_event(KIND_DELAY, 8'd0, 16'd0);
		send_event(KIND_DELAY, 8'd0, 16'd2);
		send_event(KIND_TICK, 8'd0, 16'd0);
		send_event(KIND_TICK, 8'd0, 16'd0);
		send_event(KIND_DELAY, 8'd0, 16'hFFFF);
		send_event(KIND_DELAY, 8'd0, 16'd64);
		send_event(KIND_DELAY, 8'd0, 16'd3);
		send_event(KIND_CREATE, 8'd0, 16'd0);
	endtask

	// A create inside an interrupt still reschedules; only the exit that
	// returns to depth zero runs the selector.
	task automatic test_irq_nesting();
		send_event(KIND_IRQ_ENTER, 8'd0, 16'd0);
		send_event(KIND_CREATE, 8'd99, 16'd0);
		send_event(KIND_IRQ_EXIT, 8'd0, 16'd0);
		send_event(KIND_IRQ_ENTER, 8'd0, 16'd0);
		send_event(KIND_IRQ_ENTER, 8'd0, 16'd0);
		send_event(KIND_IRQ_EXIT, 8'd0, 16'd0);
		send_event(KIND_IRQ_EXIT, 8'd0, 16'd0);
	endtask

	// Fill the remaining slots, one at the priority limit, then overflow.
	task automatic test_table_full();
		send_event(KIND_CREATE, PRIO_LIMIT, 16'd0);
		send_event(KIND_CREATE, 8'($urandom_range(0, 120)), 16'($urandom));
		send_event(KIND_CREATE, 8'($urandom_range(0, 120)), 16'($urandom));
		send_event(KIND_CREATE, 8'($urandom), 16'($urandom));
	endtask

	// Nest past the top so the depth saturates, then unwind all the way and
	// two more, which land on depth zero and must be ignored.
	task automatic test_irq_saturation();
		repeat (257)
			send_event(KIND_IRQ_ENTER, 8'($urandom), 16'($urandom));
		repeat (257)
			send_event(KIND_IRQ_EXIT, 8'($urandom), 16'($urandom));
	endtask

	// Random traffic weighted toward what moves the selector: delays of the
	// running task and ticks that wake sleepers. Interrupt exits are favored
	// while nested so the depth keeps returning to zero. Halfway through the
	// sender goes quiet until the block has answered everything.
	task automatic test_random_traffic();
		int          roll;
		logic [2:0]  kind;
		logic [15:0] dly;
		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			if (n == RANDOM_EVENTS / 2)
				wait_for_responses();
			roll = $urandom_range(0, 99);
			if (roll < 30)
				kind = KIND_DELAY;
			else if (roll < 65)
				kind = KIND_TICK;
			else if (roll < 75)
				kind = KIND_IRQ_ENTER;
			else if (roll < 87)
				kind = (irq_depth != '0 || $urandom_range(0, 3) == 0)
					? KIND_IRQ_EXIT : KIND_IRQ_ENTER;
			else if (roll < 93)
				kind = KIND_CREATE;
			else if (roll < 97)
				kind = KIND_START;
			else
				kind = ($urandom_range(0, 1) == 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
			// Mostly short sleeps so tasks come back within the run.
			roll = $urandom_range(0, 99);
			if (kind != KIND_DELAY)
				dly = 16'($urandom);
			else if (roll < 15)
				dly = '0;
			else if (roll < 80)
				dly = 16'($urandom_range(1, 5));
			else if (roll < 97)
				dly = 16'($urandom_range(6, 40));
			else
				dly = 16'($urandom);
			send_event(kind, 8'($urandom), dly);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		clear_sched_model();
		pending_sched_rsp.delete();
		events_sent = 0;
		mismatches  = 0;
		seen_first  = 0;
		seen_switch = 0;
		seen_full   = 0;
		burst_left  = 0;

		// The release lands on a rising edge as a nonblocking update, so the
		// block still sees reset at that edge and comes out at the next one.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_before_start();
		test_create_and_start();
		test_delay_paths();
		test_irq_nesting();
		test_table_full();
		test_irq_saturation();
		test_random_traffic();

		wait_for_responses();
		// Let any stray response surface before the verdict.
		repeat (40) @(posedge clk);

		$display("Covered %0d kernel events: %0d first dispatches, %0d switches,",
			events_sent, seen_first, seen_switch);
		$display("%0d full-table rejects; nesting peaked at %0d; %0d ticks; %0d mismatches.",
			seen_full, peak_depth, tick_total, mismatches);
		if (mismatches == 0 && pending_sched_rsp.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: well beyond the slowest legal run of about six hundred
	// events with full stalls and gaps on every one.
	initial begin
		#10_000_000;
		$display("Timed out with %0d responses outstanding.", pending_sched_rsp.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/pst_pkg.sv
rtl/pst_front.sv
rtl/pst_queue.sv
rtl/pst_exec.sv
rtl/priority_task_scheduler.sv
bench/tb_top.sv
